@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// plain invariant
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

@@ rtl/core/tsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tsr_pkg
// types and codes shared by the transfer session receiver and its checker
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_ACCEPT   = 2'd1;
    localparam logic [1:0] KIND_REJECT   = 2'd2;
    localparam logic [1:0] KIND_RECEIVED = 2'd3;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_CONN_TYPE = 4'd1;
    localparam logic [3:0] ERR_PROTOCOL  = 4'd2;
    localparam logic [3:0] ERR_SESSION   = 4'd3;
    localparam logic [3:0] ERR_SEQUENCE  = 4'd4;
    localparam logic [3:0] ERR_DATA_TYPE = 4'd5;
    localparam logic [3:0] ERR_OVERRUN   = 4'd6;
    localparam logic [3:0] ERR_CHUNK_LEN = 4'd7;
    localparam logic [3:0] ERR_LINK      = 4'd8;

    localparam int          PADDR_W = 5;
    localparam logic [2:0] REG_EXP_PROTOCOL = 3'd0;
    localparam logic [2:0] REG_CONNECT_TYPE = 3'd1;
    localparam logic [2:0] REG_DATA_TYPE    = 3'd2;
    localparam logic [2:0] REG_MIN_CHUNK    = 3'd3;
    localparam logic [2:0] REG_MAX_CHUNK    = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] session;
        logic [63:0] number;
        logic [3:0]  error;
        logic        last;
    } resp_t;

endpackage

@@ rtl/core/transfer_session_receiver.sv @@
// ----------------------------------------------------------------------------
// transfer_session_receiver
// session tracking for decoded transfer headers: connect check, data checks,
// accept / reject / received responses and error status responses
// ----------------------------------------------------------------------------
// One header is taken per clock while in_stall is low. A header is registered
// on entry and checked against the session state while it is held in the
// input stage, where a single 65-bit add and compare decides overrun; its
// responses go into a four-entry response queue whose head entry drives the
// output ports, so responses are registered in the queue before they reach
// the ports. Output drains one response per clock while out_stall is low: a
// connect with a zero total gives two responses (accept, then received), a
// good data header short of the total gives none. The input stalls while a
// header is held and the queue has fewer than two free entries.
module transfer_session_receiver (
    input  logic                         clk,
    input  logic                         rst_n,
    // input transactions
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         link_broken,
    input  logic [7:0]                   hdr_type,
    input  logic [7:0]                   hdr_protocol,
    input  logic [63:0]                  hdr_session,
    input  logic [63:0]                  hdr_seq,
    input  logic [63:0]                  total_length,
    input  logic [31:0]                  chunk_length,
    // output transactions
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   response_kind,
    output logic [63:0]                  response_session,
    output logic [63:0]                  response_number,
    output logic [3:0]                   error_code,
    output logic                         last,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tsr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import tsr_pkg::*;

    // configuration registers
    logic [7:0]  exp_protocol_reg;
    logic [7:0]  connect_type_reg;
    logic [7:0]  data_type_reg;
    logic [31:0] min_chunk_reg;
    logic [31:0] max_chunk_reg;
    logic        cfg_write;
    logic [2:0]  cfg_index;

    // input stage
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_broken_reg;
    logic [7:0]  s1_type_reg;
    logic [7:0]  s1_proto_reg;
    logic [63:0] s1_session_reg;
    logic [63:0] s1_number_reg;
    logic [63:0] s1_total_reg;
    logic [31:0] s1_chunk_reg;
    logic        s1_load;

    // session state
    logic        data_phase_reg, data_phase_next;
    logic [63:0] active_session_reg, active_session_next;
    logic [63:0] expected_number_reg, expected_number_next;
    logic [63:0] bytes_received_reg, bytes_received_next;
    logic [63:0] announced_total_reg, announced_total_next;

    // response queue
    resp_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic        process;
    logic        pop;
    logic [1:0]  n_push;
    resp_t       res0;
    resp_t       res1;
    logic [64:0] byte_sum;
    logic [63:0] number_inc;
    logic [3:0]  data_err;
    resp_t       head_entry;

    // ------------------------------------------------------------------
    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_protocol_reg <= 8'd1;
            connect_type_reg <= 8'd1;
            data_type_reg    <= 8'd4;
            min_chunk_reg    <= 32'd1;
            max_chunk_reg    <= 32'd64000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_EXP_PROTOCOL: exp_protocol_reg <= pwdata[7:0];
                REG_CONNECT_TYPE: connect_type_reg <= pwdata[7:0];
                REG_DATA_TYPE:    data_type_reg    <= pwdata[7:0];
                REG_MIN_CHUNK:    min_chunk_reg    <= pwdata;
                REG_MAX_CHUNK:    max_chunk_reg    <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_EXP_PROTOCOL: prdata = {24'd0, exp_protocol_reg};
            REG_CONNECT_TYPE: prdata = {24'd0, connect_type_reg};
            REG_DATA_TYPE:    prdata = {24'd0, data_type_reg};
            REG_MIN_CHUNK:    prdata = min_chunk_reg;
            REG_MAX_CHUNK:    prdata = max_chunk_reg;
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshakes
    assign process  = s1_valid_reg && (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign in_stall = s1_valid_reg && !process;
    assign s1_load  = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (process)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_broken_reg  <= link_broken;
            s1_type_reg    <= hdr_type;
            s1_proto_reg   <= hdr_protocol;
            s1_session_reg <= hdr_session;
            s1_number_reg  <= hdr_seq;
            s1_total_reg   <= total_length;
            s1_chunk_reg   <= chunk_length;
        end
    end

    // ------------------------------------------------------------------
    // header checks
    assign byte_sum   = {1'b0, bytes_received_reg} + {33'd0, s1_chunk_reg};
    assign number_inc = expected_number_reg + 64'd1;

    always_comb
    begin
        if (s1_session_reg != active_session_reg)
            data_err = ERR_SESSION;
        else if (s1_number_reg != expected_number_reg)
            data_err = ERR_SEQUENCE;
        else if (s1_type_reg != data_type_reg)
            data_err = ERR_DATA_TYPE;
        else if (byte_sum > {1'b0, announced_total_reg})
            data_err = ERR_OVERRUN;
        else if (s1_chunk_reg < min_chunk_reg || s1_chunk_reg > max_chunk_reg)
            data_err = ERR_CHUNK_LEN;
        else
            data_err = ERR_NONE;
    end

    always_comb
    begin
        data_phase_next      = data_phase_reg;
        active_session_next  = active_session_reg;
        expected_number_next = expected_number_reg;
        bytes_received_next  = bytes_received_reg;
        announced_total_next = announced_total_reg;
        n_push               = 2'd0;
        res0                 = '{KIND_NONE, s1_session_reg, 64'd0, ERR_NONE, 1'b1};
        res1                 = '{KIND_RECEIVED, s1_session_reg, 64'd0, ERR_NONE, 1'b1};

        if (s1_broken_reg)
        begin
            res0 = '{KIND_NONE, active_session_reg, expected_number_reg, ERR_LINK, 1'b1};
            n_push = 2'd1;
            data_phase_next      = 1'b0;
            active_session_next  = 64'd0;
            expected_number_next = 64'd0;
            bytes_received_next  = 64'd0;
            announced_total_next = 64'd0;
        end
        else if (!data_phase_reg)
        begin
            n_push = 2'd1;
            if (s1_type_reg != connect_type_reg)
                res0.error = ERR_CONN_TYPE;
            else if (s1_proto_reg != exp_protocol_reg)
                res0.error = ERR_PROTOCOL;
            else if (s1_total_reg == 64'd0)
            begin
                res0.kind = KIND_ACCEPT;
                res0.last = 1'b0;
                n_push    = 2'd2;
            end
            else
            begin
                res0.kind            = KIND_ACCEPT;
                data_phase_next      = 1'b1;
                active_session_next  = s1_session_reg;
                announced_total_next = s1_total_reg;
                expected_number_next = 64'd0;
                bytes_received_next  = 64'd0;
            end
        end
        else if (data_err != ERR_NONE)
        begin
            res0 = '{KIND_REJECT, s1_session_reg, expected_number_reg, data_err, 1'b1};
            n_push = 2'd1;
            data_phase_next      = 1'b0;
            active_session_next  = 64'd0;
            expected_number_next = 64'd0;
            bytes_received_next  = 64'd0;
            announced_total_next = 64'd0;
        end
        else if (byte_sum[63:0] == announced_total_reg)
        begin
            res0 = '{KIND_RECEIVED, active_session_reg, number_inc, ERR_NONE, 1'b1};
            n_push = 2'd1;
            data_phase_next      = 1'b0;
            active_session_next  = 64'd0;
            expected_number_next = 64'd0;
            bytes_received_next  = 64'd0;
            announced_total_next = 64'd0;
        end
        else
        begin
            expected_number_next = number_inc;
            bytes_received_next  = byte_sum[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_phase_reg      <= 1'b0;
            active_session_reg  <= 64'd0;
            expected_number_reg <= 64'd0;
            bytes_received_reg  <= 64'd0;
            announced_total_reg <= 64'd0;
        end
        else if (process)
        begin
            data_phase_reg      <= data_phase_next;
            active_session_reg  <= active_session_next;
            expected_number_reg <= expected_number_next;
            bytes_received_reg  <= bytes_received_next;
            announced_total_reg <= announced_total_next;
        end
    end

    // ------------------------------------------------------------------
    // response queue
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (process)
        begin
            tail_next  = tail_reg + QPTR_W'(n_push);
            count_next = count_next + QCNT_W'(n_push);
        end
        if (pop)
        begin
            head_next  = head_reg + QPTR_W'(1);
            count_next = count_next - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && n_push != 2'd0)
            queue_reg[tail_reg] <= res0;
        if (process && n_push == 2'd2)
            queue_reg[tail_reg + QPTR_W'(1)] <= res1;
    end

    assign head_entry       = queue_reg[head_reg];
    assign out_valid        = (count_reg != '0);
    assign response_kind    = head_entry.kind;
    assign response_session = head_entry.session;
    assign response_number  = head_entry.number;
    assign error_code       = head_entry.error;
    assign last             = head_entry.last;

endmodule

@@ rtl/core/tsr_checker.sv @@
// ----------------------------------------------------------------------------
// tsr_checker
// port-level checks on the transfer session receiver, bound to each of its instances
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  response_kind,
    input logic [63:0] response_session,
    input logic [63:0] response_number,
    input logic [3:0]  error_code,
    input logic        last,
    input logic        pready
);
    import tsr_pkg::*;

    // stalled response transaction holds
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(response_kind) && $stable(response_session) && $stable(response_number) && $stable(error_code) && $stable(last), "response changed while stalled")

    // reject carries a data-phase error
    `ASSERT_IMPL(a_reject_err, out_valid && response_kind == KIND_REJECT, error_code >= ERR_SESSION && error_code <= ERR_CHUNK_LEN, "reject with wrong error code")

    // accept is clean and starts at sequence zero
    `ASSERT_IMPL(a_accept_clean, out_valid && response_kind == KIND_ACCEPT, error_code == ERR_NONE && response_number == 64'd0, "accept with error or nonzero number")

    // link abort is a single status response
    `ASSERT_IMPL(a_link_status, out_valid && error_code == ERR_LINK, response_kind == KIND_NONE && last, "link abort with wrong kind or not last")

    `ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind transfer_session_receiver tsr_checker u_tsr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .response_kind    (response_kind),
    .response_session (response_session),
    .response_number  (response_number),
    .error_code       (error_code),
    .last             (last),
    .pready           (pready)
);
